// File: hw/rtl/csem_pkg.sv
package csem_pkg;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_QUERY = 3'd1,
    REQ_UP    = 3'd2,
    REQ_DOWN  = 3'd3,
    REQ_FREE  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOSLOT    = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_SUSPENDED = 3'd5,
    ST_BUSY      = 3'd6,
    ST_QFULL     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_NAME,
    S_EXEC,
    S_POP,
    S_REPLY
  } state_t;

  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COUNT_MIN = -16'sh8000;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic fetch;
    logic name_step;
    logic exec;
    logic pop;
    logic reply;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic auto_need;
    logic name_hit;
    logic pop_need;
    logic out_busy;
  } sts_t;

endpackage

// File: hw/rtl/csem_ctrl.sv
module csem_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  csem_pkg::sts_t sts,
  output csem_pkg::cmd_t cmd
);

  csem_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      csem_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = csem_pkg::S_SCAN;
        end
      end
      csem_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = csem_pkg::S_DRAIN;
        end
      end
      csem_pkg::S_DRAIN: begin
        state_next = csem_pkg::S_FETCH;
      end
      csem_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = sts.auto_need ? csem_pkg::S_NAME : csem_pkg::S_EXEC;
      end
      csem_pkg::S_NAME: begin
        cmd.name_step = 1'b1;
        if (sts.name_hit) begin
          state_next = csem_pkg::S_EXEC;
        end
      end
      csem_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.pop_need ? csem_pkg::S_POP : csem_pkg::S_REPLY;
      end
      csem_pkg::S_POP: begin
        cmd.pop    = 1'b1;
        state_next = csem_pkg::S_REPLY;
      end
      csem_pkg::S_REPLY: begin
        if (!sts.out_busy) begin
          cmd.reply  = 1'b1;
          state_next = csem_pkg::S_IDLE;
        end
      end
      default: state_next = csem_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/csem_dp.sv
module csem_dp #(
  parameter int SLOTS         = 64,
  parameter int QUEUE_DEPTH   = 16,
  parameter int MAX_MAGNITUDE = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  csem_pkg::cmd_t     cmd,
  output csem_pkg::sts_t     sts,
  input  logic [2:0]         req_type,
  input  logic [30:0]        sem_name,
  input  logic signed [15:0] init_value,
  input  logic [7:0]         caller_pid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [30:0]        result_name,
  output logic signed [15:0] result_count,
  output logic               woken_valid,
  output logic [7:0]         woken_pid
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(SLOTS + 2);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RW = $clog2(SLOTS * QUEUE_DEPTH);
  localparam int EW = 31 + 16 + 2 * QW;

  localparam logic signed [15:0] COUNT_MAX_L = csem_pkg::COUNT_MAX;
  localparam logic signed [15:0] COUNT_MIN_L = csem_pkg::COUNT_MIN;

  // slot word: name, count, head, tail
  logic [EW-1:0]   slot_mem [SLOTS];
  logic [EW-1:0]   slot_rd;
  logic [7:0]      ring_mem [SLOTS * QUEUE_DEPTH];
  logic [7:0]      ring_rd;
  logic [SLOTS-1:0] used;
  logic [SLOTS+1:0] name_map;

  logic [2:0]         req;
  logic [30:0]        rq_name;
  logic signed [15:0] rq_val;
  logic [7:0]         rq_pid;

  logic [NW-1:0] cnt;
  logic          proc_valid;
  logic [SW-1:0] proc_idx;
  logic          match_found, free_found;
  logic [SW-1:0] match_idx, free_idx;
  logic [30:0]   auto_name;

  logic [2:0]         res_status;
  logic [30:0]        res_name;
  logic signed [15:0] res_count;
  logic               res_wv;
  logic [7:0]         woken_hold;

  logic [30:0]        rd_name;
  logic signed [15:0] rd_count;
  logic [QW-1:0]      rd_head, rd_tail, head_inc, tail_inc;
  logic [16:0]        mag;
  logic               mag_bad, q_empty, q_full;
  logic signed [15:0] up_count, dn_count;

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
    ring_next = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  function automatic logic [RW-1:0] ring_addr(input logic [SW-1:0] s,
                                              input logic [QW-1:0] p);
    ring_addr = RW'(s) * RW'(QUEUE_DEPTH) + RW'(p);
  endfunction

  assign rd_name  = slot_rd[EW-1 -: 31];
  assign rd_count = slot_rd[2*QW+15 -: 16];
  assign rd_head  = slot_rd[2*QW-1 -: QW];
  assign rd_tail  = slot_rd[QW-1:0];
  assign head_inc = ring_next(rd_head);
  assign tail_inc = ring_next(rd_tail);
  assign q_empty  = (rd_head == rd_tail);
  assign q_full   = (tail_inc == rd_head);
  assign up_count = (rd_count != COUNT_MAX_L) ? rd_count + 16'sd1 : rd_count;
  assign dn_count = (rd_count != COUNT_MIN_L) ? rd_count - 16'sd1 : rd_count;
  assign mag      = rq_val[15] ? 17'(-{rq_val[15], rq_val}) : 17'({1'b0, rq_val});
  assign mag_bad  = (mag > 17'(MAX_MAGNITUDE));

  assign sts.scan_last = (cnt == NW'(SLOTS - 1));
  assign sts.auto_need = (req == csem_pkg::REQ_INIT) && !mag_bad && free_found
                         && (rq_name == '0);
  assign sts.name_hit  = !name_map[cnt];
  assign sts.pop_need  = (req == csem_pkg::REQ_UP) && match_found && !q_empty;
  assign sts.out_busy  = out_valid && !out_ready;

  // scan pipeline and request latch
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.scan_rd;
    end
    proc_idx <= cnt[SW-1:0];
    if (cmd.start) begin
      req         <= req_type;
      rq_name     <= sem_name;
      rq_val      <= init_value;
      rq_pid      <= caller_pid;
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      name_map    <= '0;
    end else begin
      if (cmd.scan_rd) begin
        cnt <= cnt + NW'(1);
      end
      if (cmd.fetch) begin
        cnt <= NW'(1);
      end
      if (cmd.name_step) begin
        if (!name_map[cnt]) begin
          auto_name <= 31'(cnt);
        end else begin
          cnt <= cnt + NW'(1);
        end
      end
      if (proc_valid) begin
        if (!used[proc_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= proc_idx;
        end
        if (used[proc_idx] && rd_name == rq_name && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= proc_idx;
        end
        if (used[proc_idx] && rd_name <= 31'(SLOTS + 1)) begin
          name_map[rd_name[NW-1:0]] <= 1'b1;
        end
      end
    end
  end

  // slot memory: scan reads, fetch reads the matched slot, exec writes back
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      slot_rd <= slot_mem[cnt[SW-1:0]];
    end else if (cmd.fetch) begin
      slot_rd <= slot_mem[match_idx];
    end
    if (cmd.exec) begin
      if (req == csem_pkg::REQ_INIT) begin
        if (!mag_bad && free_found && (rq_name == '0 || !match_found)) begin
          slot_mem[free_idx] <= {(rq_name == '0) ? auto_name : rq_name, rq_val,
                                 {QW{1'b0}}, {QW{1'b0}}};
        end
      end else if (match_found) begin
        if (req == csem_pkg::REQ_UP) begin
          slot_mem[match_idx] <= {rd_name, up_count,
                                  q_empty ? rd_head : head_inc, rd_tail};
        end else if (req == csem_pkg::REQ_DOWN) begin
          if (!dn_count[15]) begin
            slot_mem[match_idx] <= {rd_name, dn_count, rd_head, rd_tail};
          end else if (!q_full) begin
            slot_mem[match_idx] <= {rd_name, dn_count, rd_head, tail_inc};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && match_found && req == csem_pkg::REQ_DOWN && dn_count[15]
        && !q_full) begin
      ring_mem[ring_addr(match_idx, tail_inc)] <= rq_pid;
    end
    if (cmd.exec) begin
      ring_rd <= ring_mem[ring_addr(match_idx, head_inc)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      if (req == csem_pkg::REQ_INIT) begin
        if (!mag_bad && free_found && (rq_name == '0 || !match_found)) begin
          used[free_idx] <= 1'b1;
        end
      end else if (req == csem_pkg::REQ_FREE && match_found && q_empty) begin
        used[match_idx] <= 1'b0;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= csem_pkg::ST_INVALID;
      res_name   <= '0;
      res_count  <= '0;
      res_wv     <= 1'b0;
      case (req)
        csem_pkg::REQ_INIT: begin
          if (mag_bad) begin
            res_status <= csem_pkg::ST_INVALID;
          end else if (!free_found) begin
            res_status <= csem_pkg::ST_NOSLOT;
          end else if (rq_name != '0 && match_found) begin
            res_status <= csem_pkg::ST_EXISTS;
          end else begin
            res_status <= csem_pkg::ST_OK;
            res_name   <= (rq_name == '0) ? auto_name : rq_name;
            res_count  <= rq_val;
          end
        end
        csem_pkg::REQ_QUERY, csem_pkg::REQ_UP, csem_pkg::REQ_DOWN,
        csem_pkg::REQ_FREE: begin
          if (!match_found) begin
            res_status <= csem_pkg::ST_NOTFOUND;
          end else if (req == csem_pkg::REQ_QUERY) begin
            res_status <= csem_pkg::ST_OK;
            res_count  <= rd_count;
          end else if (req == csem_pkg::REQ_UP) begin
            res_status <= csem_pkg::ST_OK;
            res_count  <= up_count;
            res_wv     <= !q_empty;
          end else if (req == csem_pkg::REQ_DOWN) begin
            if (!dn_count[15]) begin
              res_status <= csem_pkg::ST_OK;
              res_count  <= dn_count;
            end else if (q_full) begin
              res_status <= csem_pkg::ST_QFULL;
              res_count  <= rd_count;
            end else begin
              res_status <= csem_pkg::ST_SUSPENDED;
              res_count  <= dn_count;
            end
          end else if (!q_empty) begin
            res_status <= csem_pkg::ST_BUSY;
            res_count  <= rd_count;
          end else begin
            res_status <= csem_pkg::ST_OK;
          end
        end
        default: res_status <= csem_pkg::ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      woken_hold <= ring_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.reply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.reply) begin
      status       <= res_status;
      result_name  <= res_name;
      result_count <= res_count;
      woken_valid  <= res_wv;
      woken_pid    <= res_wv ? woken_hold : 8'd0;
    end
  end

endmodule

// File: hw/rtl/counting_semaphore_table.sv
// Table of named counting semaphores, each with a FIFO of waiting process ids.
// Request channel: in_valid/in_ready carry req_type, sem_name, init_value and
// caller_pid; a request is taken at an edge with both high. Reply channel:
// out_valid/out_ready carry status, result_name, result_count, woken_valid
// and woken_pid; every request gives exactly one reply, in order.
// Each request reads the whole slot memory once, one slot per cycle, then
// fetches the matched slot, executes and replies; an up that wakes a waiter
// also pops its pid before the reply. An init with name 0, a valid value and
// a free slot walks a bitmap of names in use, one name per cycle, before it
// executes. in_ready is high only while the controller is idle, which it
// reaches at the edge that loads the reply, so a new request is taken only
// after the previous request's reply has been loaded. A finished reply waits in
// the output register; the next request may start while it waits, and its
// reply is held back until the receiver takes the previous one.
// Reset clears the in-use bits, so the table starts empty; no memory clear
// pass is needed and the block is ready as soon as reset is released.
module counting_semaphore_table #(
  parameter int SLOTS         = 64,
  parameter int QUEUE_DEPTH   = 16,
  parameter int MAX_MAGNITUDE = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [30:0]        sem_name,
  input  logic signed [15:0] init_value,
  input  logic [7:0]         caller_pid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [30:0]        result_name,
  output logic signed [15:0] result_count,
  output logic               woken_valid,
  output logic [7:0]         woken_pid
);

  csem_pkg::cmd_t cmd;
  csem_pkg::sts_t sts;

  csem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csem_dp #(
    .SLOTS         (SLOTS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_MAGNITUDE (MAX_MAGNITUDE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .sem_name     (sem_name),
    .init_value   (init_value),
    .caller_pid   (caller_pid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_name  (result_name),
    .result_count (result_count),
    .woken_valid  (woken_valid),
    .woken_pid    (woken_pid)
  );

endmodule
